FILE: rtl/core/wildcard_byte_pattern_scanner_unit_defines.svh
// assertion macros for the wildcard byte pattern scanner
// used by the top level; expects clk and rst_n in the including scope
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wbps_pkg.sv
// shared types and constants of the wildcard byte pattern scanner
// no dependencies
`default_nettype none

package wbps_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int WIN_IDX_W    = 4;
    localparam int LEN_W        = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int OFFSET_W     = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WC_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd3;

    typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

    typedef struct packed {
        logic [63:0]      pattern_low;
        logic [63:0]      pattern_high;
        logic [15:0]      wildcard_mask;
        logic [LEN_W-1:0] eff_len;
    } cfg_t;

    // one word sitting in the input stage
    typedef struct packed {
        window_t             window;
        logic [LEN_W-1:0]    fill;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic                valid;
    } stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/wbps_cfg.sv
// configuration registers and effective pattern length
// depends on wbps_pkg
`default_nettype none

module wbps_cfg #(
    parameter int PATTERN_MAX = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                wr_en,
    input  wire [wbps_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire [wbps_pkg::CFG_DATA_W-1:0]     wr_data,
    output wbps_pkg::cfg_t                     cfg
);

    localparam int LIMIT = (PATTERN_MAX < wbps_pkg::WINDOW_DEPTH) ?
                           PATTERN_MAX : wbps_pkg::WINDOW_DEPTH;
    localparam logic [wbps_pkg::LEN_W-1:0] LIMIT_LEN = wbps_pkg::LEN_W'(LIMIT);

    logic [63:0]                 pattern_low_reg;
    logic [63:0]                 pattern_high_reg;
    logic [15:0]                 wildcard_mask_reg;
    logic [wbps_pkg::LEN_W-1:0]  pattern_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::LEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                wbps_pkg::CFG_PAT_LOW:  pattern_low_reg    <= wr_data;
                wbps_pkg::CFG_PAT_HIGH: pattern_high_reg   <= wr_data;
                wbps_pkg::CFG_WC_MASK:  wildcard_mask_reg  <= wr_data[15:0];
                wbps_pkg::CFG_PAT_LEN:  pattern_length_reg <= wr_data[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern_low   = pattern_low_reg;
        cfg.pattern_high  = pattern_high_reg;
        cfg.wildcard_mask = wildcard_mask_reg;
        // zero length acts as one, oversize clamps to LIMIT
        if (pattern_length_reg == '0)
            cfg.eff_len = wbps_pkg::LEN_W'(1);
        else if (pattern_length_reg > LIMIT_LEN)
            cfg.eff_len = LIMIT_LEN;
        else
            cfg.eff_len = pattern_length_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/wbps_window.sv
// input stage: byte window shift line, fill count and byte offset
// depends on wbps_pkg
`default_nettype none

module wbps_window (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     load,
    input  wire                     drain,
    input  wire [7:0]               data_byte,
    input  wire                     last_byte,
    output wbps_pkg::stage_t        stage
);

    localparam int D = wbps_pkg::WINDOW_DEPTH;
    localparam logic [wbps_pkg::LEN_W-1:0] FULL = wbps_pkg::LEN_W'(D);

    wbps_pkg::window_t               window_reg;
    logic [wbps_pkg::LEN_W-1:0]      fill_reg;
    logic [wbps_pkg::OFFSET_W-1:0]   offset_reg;
    logic                            last_reg;
    logic                            valid_reg;

    logic [wbps_pkg::LEN_W-1:0]      fill_next;
    logic [wbps_pkg::OFFSET_W-1:0]   offset_next;

    // last_reg comes out of reset set so the first byte starts a fresh scan
    always_comb
    begin
        if (last_reg)
        begin
            fill_next   = wbps_pkg::LEN_W'(1);
            offset_next = '0;
        end
        else
        begin
            fill_next   = (fill_reg == FULL) ? FULL : fill_reg + wbps_pkg::LEN_W'(1);
            offset_next = offset_reg + wbps_pkg::OFFSET_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            offset_reg <= '0;
            last_reg   <= 1'b1;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                fill_reg   <= fill_next;
                offset_reg <= offset_next;
                last_reg   <= last_byte;
                valid_reg  <= 1'b1;
            end
            else if (drain)
            begin
                valid_reg  <= 1'b0;
            end
        end
    end

    // entries past the fill count are never compared
    always_ff @(posedge clk)
    begin
        if (load)
            window_reg <= {window_reg[D-2:0], data_byte};
    end

    assign stage.window = window_reg;
    assign stage.fill   = fill_reg;
    assign stage.offset = offset_reg;
    assign stage.last   = last_reg;
    assign stage.valid  = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wbps_match.sv
// parallel masked compare of the byte window against the pattern
// depends on wbps_pkg
`default_nettype none

module wbps_match (
    input  wire wbps_pkg::window_t        window,
    input  wire [wbps_pkg::LEN_W-1:0]     fill,
    input  wire wbps_pkg::cfg_t           cfg,
    output logic                          hit
);

    localparam int D = wbps_pkg::WINDOW_DEPTH;

    logic [2*64-1:0] pattern;
    logic [D-1:0]    lane_ok;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // pattern byte k lines up with the byte received len-1-k words ago
    always_comb
    begin
        logic [wbps_pkg::LEN_W-1:0] lane_dist;
        lane_dist = '0;
        for (int k = 0; k < D; k++)
        begin
            lane_dist = cfg.eff_len - wbps_pkg::LEN_W'(k) - wbps_pkg::LEN_W'(1);
            if (wbps_pkg::LEN_W'(k) >= cfg.eff_len || cfg.wildcard_mask[k])
                lane_ok[k] = 1'b1;
            else
                lane_ok[k] = (window[lane_dist[wbps_pkg::WIN_IDX_W-1:0]] == pattern[k*8 +: 8]);
        end
    end

    assign hit = (fill >= cfg.eff_len) && (&lane_ok);

endmodule

`default_nettype wire

FILE: rtl/core/wildcard_byte_pattern_scanner_unit.sv
// Wildcard byte pattern scanner, top level.
//
// Usage: image bytes enter on the input channel (in_valid / in_stall) with
// last_byte on the final byte of an image. Every byte gives one result word
// on the output channel (out_valid / out_stall): match_here marks the byte
// that completes the first match of the scan, match_offset holds its start
// offset once found_any is set, scan_done repeats last_byte. The byte after a
// last byte opens a new scan at offset zero.
// Pattern, wildcard mask and length are written over the cfg channel
// (cfg_index 0..3, always ready) while the scanner is idle.
// An accepted byte is held in the input register and its result in the
// result register, two registers deep. Throughput: one byte per cycle unless
// out_stall holds it, kept there by the single compare stage between them.
// Reset clears the scan state, sets length 1 and empties both stages.
// When the receiver stalls the result holds; one more byte is taken into the
// input stage, after which in_stall follows out_stall.
`default_nettype none

module wildcard_byte_pattern_scanner_unit #(
    parameter int PATTERN_MAX = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire [7:0]                          data_byte,
    input  wire                                last_byte,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic                               match_here,
    output logic [wbps_pkg::OFFSET_W-1:0]      match_offset,
    output logic                               scan_done,
    output logic                               found_any
);

`include "wildcard_byte_pattern_scanner_unit_defines.svh"

    wbps_pkg::cfg_t    cfg;
    wbps_pkg::stage_t  stage;

    logic out_free;
    logic in_accept;
    logic advance;
    logic window_hit;
    logic first_hit;
    logic found_now;

    logic [wbps_pkg::OFFSET_W-1:0] offset_now;

    logic                           found_latch_reg;
    logic [wbps_pkg::OFFSET_W-1:0]  first_offset_reg;
    logic                           out_valid_reg;
    logic                           match_here_reg;
    logic [wbps_pkg::OFFSET_W-1:0]  match_offset_reg;
    logic                           scan_done_reg;
    logic                           found_any_reg;

    assign cfg_ready = 1'b1;

    wbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = stage.valid && out_free;
    assign in_stall  = stage.valid && !out_free;
    assign in_accept = in_valid && !in_stall;

    wbps_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .drain     (advance),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .stage     (stage)
    );

    wbps_match u_match (
        .window (stage.window),
        .fill   (stage.fill),
        .cfg    (cfg),
        .hit    (window_hit)
    );

    assign first_hit  = window_hit && !found_latch_reg;
    assign found_now  = found_latch_reg || first_hit;
    assign offset_now = first_hit ?
                        stage.offset - wbps_pkg::OFFSET_W'(cfg.eff_len - wbps_pkg::LEN_W'(1)) :
                        first_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_latch_reg  <= 1'b0;
            first_offset_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                found_latch_reg  <= found_now && !stage.last;
                first_offset_reg <= offset_now;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            match_here_reg   <= first_hit;
            match_offset_reg <= found_now ? offset_now : '0;
            scan_done_reg    <= stage.last;
            found_any_reg    <= found_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_here   = match_here_reg;
    assign match_offset = match_offset_reg;
    assign scan_done    = scan_done_reg;
    assign found_any    = found_any_reg;

    `WBPS_ASSERT_NOW(a_hit_sets_found, out_valid && match_here, found_any,
        "match_here without found_any")
    `WBPS_ASSERT_NOW(a_offset_zero_when_none, out_valid && !found_any, match_offset == '0,
        "nonzero offset before any match")
    `WBPS_ASSERT_NEXT(a_stage_held, stage.valid && !advance, stage.valid,
        "input stage word dropped while blocked")

endmodule

`default_nettype wire

FILE: tb/tb_wildcard_byte_pattern_scanner_unit.sv
// testbench for the wildcard byte pattern scanner: random images with planted patterns
// depends on wbps_pkg and wildcard_byte_pattern_scanner_unit; stands alone otherwise
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_unit;

    localparam int PATTERN_LIMIT  = 16;
    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 660;
    localparam int PHASE_BYTES    = 80;
    localparam int QUIET_BYTES    = 100;
    localparam int STUCK_LIMIT    = 1000;

    typedef struct packed {
        logic                          here;
        logic [wbps_pkg::OFFSET_W-1:0] offset;
        logic                          done;
        logic                          found;
    } scan_result_t;

    // tracks the scan state and queues the expected result word per input byte
    class match_tracker;
        logic [63:0]                   pat_low;
        logic [63:0]                   pat_high;
        logic [15:0]                   wc_mask;
        logic [wbps_pkg::LEN_W-1:0]    pat_len;
        logic [7:0]                    history [wbps_pkg::WINDOW_DEPTH];
        logic [wbps_pkg::OFFSET_W-1:0] next_offset;
        int                            fill;
        logic                          found;
        logic [wbps_pkg::OFFSET_W-1:0] first_offset;
        scan_result_t                  awaited [$];
        int                            errors;
        int                            first_hits;

        function new();
            pat_low      = '0;
            pat_high     = '0;
            wc_mask      = '0;
            pat_len      = wbps_pkg::LEN_W'(1);
            foreach (history[i])
                history[i] = '0;
            next_offset  = '0;
            fill         = 0;
            found        = 1'b0;
            first_offset = '0;
            errors       = 0;
            first_hits   = 0;
        endfunction

        function void write_register(logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                                     logic [wbps_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                wbps_pkg::CFG_PAT_LOW:  pat_low  = val;
                wbps_pkg::CFG_PAT_HIGH: pat_high = val;
                wbps_pkg::CFG_WC_MASK:  wc_mask  = val[15:0];
                wbps_pkg::CFG_PAT_LEN:  pat_len  = val[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_length();
            int len;
            len = pat_len;
            if (len == 0)
                len = 1;
            if (len > PATTERN_LIMIT)
                len = PATTERN_LIMIT;
            if (len > wbps_pkg::WINDOW_DEPTH)
                len = wbps_pkg::WINDOW_DEPTH;
            return len;
        endfunction

        function logic [7:0] pattern_at(int k);
            return (k < 8) ? pat_low[k*8 +: 8] : pat_high[(k-8)*8 +: 8];
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            scan_result_t res;
            int           len;
            logic         hit;
            len = active_length();
            for (int d = wbps_pkg::WINDOW_DEPTH - 1; d > 0; d--)
                history[d] = history[d-1];
            history[0] = b;
            if (fill < wbps_pkg::WINDOW_DEPTH)
                fill++;
            hit = (fill >= len);
            for (int k = 0; k < len; k++)
                if (!wc_mask[k] && history[len-1-k] != pattern_at(k))
                    hit = 1'b0;
            res.here = 1'b0;
            if (!found && hit) begin
                res.here     = 1'b1;
                found        = 1'b1;
                first_offset = next_offset - wbps_pkg::OFFSET_W'(len - 1);
            end
            res.offset = found ? first_offset : '0;
            res.done   = last;
            res.found  = found;
            awaited = {awaited, res};
            next_offset++;
            // a new image starts from scratch
            if (last) begin
                next_offset = '0;
                fill        = 0;
                found       = 1'b0;
            end
        endfunction

        function void check_result(logic here, logic [wbps_pkg::OFFSET_W-1:0] offset,
                                   logic done, logic fnd);
            scan_result_t want;
            if (awaited.size() == 0) begin
                $error("result word with no byte outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (want.here)
                first_hits++;
            if (here !== want.here) begin
                $error("match_here: expected %0d, got %0d", want.here, here);
                errors++;
            end
            if (offset !== want.offset) begin
                $error("match_offset: expected %0d, got %0d", want.offset, offset);
                errors++;
            end
            if (done !== want.done) begin
                $error("scan_done: expected %0d, got %0d", want.done, done);
                errors++;
            end
            if (fnd !== want.found) begin
                $error("found_any: expected %0d, got %0d", want.found, fnd);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      data_byte;
    logic                            last_byte;
    logic                            out_valid;
    logic                            out_stall;
    logic                            match_here;
    logic [wbps_pkg::OFFSET_W-1:0]   match_offset;
    logic                            scan_done;
    logic                            found_any;

    match_tracker tracker;
    int           bytes_sent;
    int           scans_ended;
    int           in_gap_pct;
    int           out_stall_pct;
    bit           quiet;
    int           stuck_cycles;

    // tb view of the programmed pattern, used to plant matches
    logic [7:0]   plant_bytes [PATTERN_LIMIT];
    logic [15:0]  plant_mask;
    int           plant_len;

    wildcard_byte_pattern_scanner_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_here   (match_here),
        .match_offset (match_offset),
        .scan_done    (scan_done),
        .found_any    (found_any)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver side: random stall bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < out_stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(match_here, match_offset, scan_done, found_any);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_byte(b, last);
        bytes_sent++;
        if (last)
            scans_ended++;
    endtask

    // drain every result, then give the two stages time to empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_scanner(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [15:0] mask,
                                   input logic [wbps_pkg::LEN_W-1:0] len,
                                   input bit stray);
        logic [wbps_pkg::CFG_IDX_W-1:0]  idx [$];
        logic [wbps_pkg::CFG_DATA_W-1:0] val [$];
        if (stray)
        begin
            // indexes past the register file must be dropped
            idx = {idx, wbps_pkg::CFG_IDX_W'($urandom_range(wbps_pkg::CFG_PAT_LEN + 1,
                                                          (1 << wbps_pkg::CFG_IDX_W) - 1))};
            val = {val, {$urandom, $urandom}};
        end
        idx = {idx, wbps_pkg::CFG_PAT_LOW};
        val = {val, lo};
        idx = {idx, wbps_pkg::CFG_PAT_HIGH};
        val = {val, hi};
        idx = {idx, wbps_pkg::CFG_WC_MASK};
        val = {val, {48'($urandom), mask}};
        idx = {idx, wbps_pkg::CFG_PAT_LEN};
        val = {val, {59'($urandom), len}};
        foreach (idx[i])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.write_register(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        for (int k = 0; k < PATTERN_LIMIT; k++)
            plant_bytes[k] = tracker.pattern_at(k);
        plant_mask = tracker.wc_mask;
        plant_len  = tracker.active_length();
    endtask

    // one image: noise, one or two planted patterns, or those each with a byte broken
    task automatic run_scan();
        logic [7:0] img [$];
        int         n;
        int         pos;
        int         mode;
        int         k;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(plant_len, plant_len + 30);
        for (int i = 0; i < n; i++)
            if (mode >= 2 && $urandom_range(0, 1) == 1)
                img = {img, plant_bytes[$urandom_range(0, plant_len - 1)]};
            else
                img = {img, 8'($urandom)};
        if (mode >= 2 && n >= plant_len)
        begin
            for (int copy = 0; copy < (($urandom_range(0, 2) == 0) ? 2 : 1); copy++)
            begin
                if ($urandom_range(0, 2) == 0)
                    pos = n - plant_len;
                else
                    pos = $urandom_range(0, n - plant_len);
                for (int j = 0; j < plant_len; j++)
                    if (!plant_mask[j])
                        img[pos + j] = plant_bytes[j];
                if (mode == 9)
                begin
                    k = $urandom_range(0, plant_len - 1);
                    img[pos + k] = img[pos + k] ^ 8'($urandom_range(1, 255));
                end
            end
        end
        for (int i = 0; i < n; i++)
            send_byte(img[i], i == n - 1);
    endtask

    initial
    begin
        int                         phase;
        int                         phase_start;
        logic [63:0]                lo;
        logic [63:0]                hi;
        logic [15:0]                mask;
        logic [wbps_pkg::LEN_W-1:0] len;
        logic [7:0]                 dir_bytes [9];
        logic                       dir_last [9];

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        tracker       = new();
        bytes_sent    = 0;
        scans_ended   = 0;
        in_gap_pct    = 20;
        out_stall_pct = 20;
        quiet         = 1'b0;
        stuck_cycles  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is a single zero byte
        dir_bytes = '{8'hFF, 8'h00, 8'h00, 8'hAA, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F};
        dir_last  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        for (int i = 0; i < 9; i++)
            send_byte(dir_bytes[i], dir_last[i]);

        // full-length pattern that completes on the last byte of the image
        wait_drained();
        program_scanner(64'hFFFF_FFFF_FFFF_FFFF, 64'h00FF_807F_0001_FE00, 16'h0000,
                        wbps_pkg::LEN_W'(16), 1'b1);
        for (int k = 0; k < 16; k++)
            send_byte(plant_bytes[k], k == 15);

        phase = 0;
        while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES)
        begin
            wait_drained();
            lo   = {$urandom, $urandom};
            hi   = {$urandom, $urandom};
            mask = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom & $urandom & $urandom);
            len  = wbps_pkg::LEN_W'($urandom_range(1, 16));
            case (phase)
                0: len = '0;
                1:
                begin
                    len  = wbps_pkg::LEN_W'(17);
                    mask = 16'hFFFF;
                end
                2:
                begin
                    len = wbps_pkg::LEN_W'(31);
                    lo  = '0;
                    hi  = '0;
                end
                3:
                begin
                    len  = wbps_pkg::LEN_W'(1);
                    mask = 16'hFFFF;
                end
                4: len = wbps_pkg::LEN_W'(2);
                default: ;
            endcase
            if (bytes_sent >= DIRECTED_BYTES + RANDOM_BYTES - QUIET_BYTES)
                quiet = 1'b1;
            in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            program_scanner(lo, hi, mask, len, $urandom_range(0, 1) == 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                run_scan();
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d bytes in %0d images over %0d pattern settings, %0d first matches",
                 bytes_sent, scans_ended, phase + 2, tracker.first_hits);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/wbps_pkg.sv
rtl/core/wbps_cfg.sv
rtl/core/wbps_window.sv
rtl/core/wbps_match.sv
rtl/core/wildcard_byte_pattern_scanner_unit.sv
tb/tb_wildcard_byte_pattern_scanner_unit.sv
